### rtl/tile_dma_bank_interleave_macros.svh
// ----------------------------------------------------------------------------
// Tile DMA bank interleave: assertion macros
// These are shared checks that are written once for the RTL modules to use.
// ----------------------------------------------------------------------------
`ifndef TILE_DMA_BANK_INTERLEAVE_MACROS_SVH
`define TILE_DMA_BANK_INTERLEAVE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDBI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDBI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tdbi_pkg.sv
// ----------------------------------------------------------------------------
// Tile DMA bank interleave: package
// Shared constants, codes and beat types for the tile address generator.
// ----------------------------------------------------------------------------
package tdbi_pkg;

	localparam int UNITS       = 8;
	localparam int ROW_W       = 12;
	localparam int CHECK_BANKS = 4;
	localparam int MAX_BANKS   = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int LEN_W       = 10;
	localparam int READ_END_W  = 21;
	localparam int BANK_CNT_W  = 5;

	localparam logic [BANK_CNT_W-1:0] BANK_COUNT_RESET = 5'd4;

	typedef enum logic [0:0] {
		OP_SUBMIT = 1'b0,
		OP_TICK   = 1'b1
	} op_e_t;

	typedef enum logic [0:0] {
		KIND_STATUS = 1'b0,
		KIND_XFER   = 1'b1
	} kind_e_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED  = 2'd0,
		ST_BUSY      = 2'd1,
		ST_NOT_READY = 2'd2
	} status_e_t;

	typedef struct packed {
		op_e_t       op;
		logic        is_store;
		logic [2:0]  unit;
		logic [3:0]  first_bank;
		logic [31:0] dram_base;
		logic [11:0] buffer_row;
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] image_width;
		logic [10:0] tile_cols;
		logic [10:0] tile_rows;
		logic [10:0] sq_side;
	} item_t;

	typedef struct packed {
		kind_e_t     kind;
		status_e_t   status;
		logic        xfer_store;
		logic [31:0] dram_addr;
		logic [2:0]  xfer_unit;
		logic [3:0]  bank;
		logic [11:0] row;
		logic        last;
	} result_t;

	// A classified item as the back end sees it.
	typedef struct packed {
		op_e_t                 op;
		logic                  is_store;
		logic [2:0]            unit;
		logic [3:0]            first_bank;
		logic [31:0]           line_base;
		logic [ROW_W-1:0]      buffer_row;
		logic [READ_END_W-1:0] read_end;
		logic [15:0]           stride;
		logic [LEN_W-1:0]      last_col;
		logic [LEN_W-1:0]      last_elem;
	} job_t;

endpackage

### rtl/tdbi_queue.sv
// ----------------------------------------------------------------------------
// Tile DMA bank interleave: beat queue
// A short first-in first-out queue of beats with registered storage.
// ----------------------------------------------------------------------------
module tdbi_queue #(
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int D  = tdbi_pkg::QUEUE_DEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	T              mem_q [D];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(D));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

### rtl/tdbi_front.sv
// ----------------------------------------------------------------------------
// Tile DMA bank interleave: front end
// Classifies an incoming beat and works out everything that does not depend
// on the tile state: the first line address, the store read end and lengths.
// ----------------------------------------------------------------------------
module tdbi_front #(
	parameter int UNITS = tdbi_pkg::UNITS
) (
	input  tdbi_pkg::item_t item,
	output tdbi_pkg::job_t  job
);

	localparam int LW = tdbi_pkg::LEN_W;

	logic [2:0]  unit_mod [8];
	logic [31:0] origin_prod;
	logic [21:0] square_prod;

	// The unit index is only three bits, so its remainder is a small table.
	for (genvar v = 0; v < 8; v++) begin : g_unit_mod
		assign unit_mod[v] = 3'(v % UNITS);
	end

	function automatic logic [LW-1:0] clamp_len(input logic [10:0] v);
		logic [LW-1:0] r;
		if (v == 11'd0) begin
			r = '0;
		end else if (v > 11'd1024) begin
			r = '1;
		end else begin
			r = LW'(v - 11'd1);
		end
		return r;
	endfunction

	assign origin_prod = item.start_x * item.image_width;
	assign square_prod = item.sq_side * item.sq_side;

	always_comb begin
		job            = '0;
		job.op         = item.op;
		job.is_store   = item.is_store;
		job.unit       = unit_mod[item.unit];
		job.first_bank = item.first_bank;
		job.line_base  = item.dram_base + origin_prod + 32'(item.start_y);
		job.buffer_row = item.buffer_row;
		job.read_end   = tdbi_pkg::READ_END_W'(square_prod / tdbi_pkg::CHECK_BANKS)
			+ tdbi_pkg::READ_END_W'(item.buffer_row);
		job.stride     = item.image_width;
		job.last_col   = clamp_len(item.tile_cols);
		job.last_elem  = clamp_len(item.tile_rows);
	end

endmodule

### rtl/tdbi_back.sv
// ----------------------------------------------------------------------------
// Tile DMA bank interleave: back end
// Holds the tile walk state and the per-unit write pointers, answers submits
// and issues one transfer descriptor per tick while a tile is active.
// ----------------------------------------------------------------------------
`include "tile_dma_bank_interleave_macros.svh"

module tdbi_back #(
	parameter int UNITS = tdbi_pkg::UNITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [tdbi_pkg::BANK_CNT_W-1:0]     bank_count,
	input  tdbi_pkg::job_t                      job,
	input  logic                                job_empty,
	output logic                                job_pop,
	output tdbi_pkg::result_t                   res,
	output logic                                res_push,
	input  logic                                res_full
);

	localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int RW = tdbi_pkg::ROW_W;
	localparam int LW = tdbi_pkg::LEN_W;
	localparam int BW = tdbi_pkg::BANK_CNT_W;

	logic             active_q, active_d;
	logic             cur_store_q, cur_store_d;
	logic [2:0]       cur_unit_q, cur_unit_d;
	logic [31:0]      line_base_q, line_base_d;
	logic [LW-1:0]    col_q, col_d;
	logic [LW-1:0]    elem_q, elem_d;
	logic [3:0]       bank_q, bank_d;
	logic [RW-1:0]    row_q, row_d;
	logic [15:0]      stride_q, stride_d;
	logic [LW-1:0]    cols_q, cols_d;
	logic [LW-1:0]    rows_q, rows_d;
	logic [RW-1:0]    wp_q [UNITS];

	logic             go;
	logic [RW-1:0]    wp_rd;
	logic [BW-1:0]    nbanks;
	logic [BW-1:0]    bank_inc;
	logic             bank_wrap;
	logic [RW-1:0]    row_adv;
	logic             is_last;
	logic             wp_we;
	logic [RW-1:0]    wp_wdata;

	assign go      = !job_empty && !res_full;
	assign job_pop = go;
	assign wp_rd   = wp_q[UW'(job.unit)];

	assign nbanks    = (bank_count > BW'(tdbi_pkg::MAX_BANKS)) ?
		BW'(tdbi_pkg::MAX_BANKS) : bank_count;
	assign bank_inc  = BW'(bank_q) + 1'b1;
	assign bank_wrap = (bank_inc >= nbanks);
	assign row_adv   = bank_wrap ? row_q + 1'b1 : row_q;
	assign is_last   = (col_q == cols_q) && (elem_q == rows_q);

	always_comb begin
		active_d    = active_q;
		cur_store_d = cur_store_q;
		cur_unit_d  = cur_unit_q;
		line_base_d = line_base_q;
		col_d       = col_q;
		elem_d      = elem_q;
		bank_d      = bank_q;
		row_d       = row_q;
		stride_d    = stride_q;
		cols_d      = cols_q;
		rows_d      = rows_q;
		wp_we       = 1'b0;
		wp_wdata    = row_adv + 1'b1;
		res         = '0;
		res_push    = 1'b0;
		if (go) begin
			unique case (job.op)
				tdbi_pkg::OP_SUBMIT: begin
					res_push = 1'b1;
					res.kind = tdbi_pkg::KIND_STATUS;
					if (active_q) begin
						res.status = tdbi_pkg::ST_BUSY;
					end else if (job.is_store &&
						(job.read_end > tdbi_pkg::READ_END_W'(wp_rd))) begin
						res.status = tdbi_pkg::ST_NOT_READY;
					end else begin
						res.status  = tdbi_pkg::ST_ACCEPTED;
						active_d    = 1'b1;
						cur_store_d = job.is_store;
						cur_unit_d  = job.unit;
						line_base_d = job.line_base;
						col_d       = '0;
						elem_d      = '0;
						bank_d      = job.first_bank;
						row_d       = job.is_store ? job.buffer_row : wp_rd + 1'b1;
						stride_d    = job.stride;
						cols_d      = job.last_col;
						rows_d      = job.last_elem;
					end
				end
				tdbi_pkg::OP_TICK: begin
					if (active_q) begin
						res_push       = 1'b1;
						res.kind       = tdbi_pkg::KIND_XFER;
						res.status     = tdbi_pkg::ST_ACCEPTED;
						res.xfer_store = cur_store_q;
						res.dram_addr  = line_base_q + 32'(elem_q);
						res.xfer_unit  = cur_unit_q;
						res.bank       = bank_q;
						res.row        = row_q;
						res.last       = is_last;
						bank_d         = bank_wrap ? 4'd0 : bank_inc[3:0];
						row_d          = row_adv;
						if (elem_q >= rows_q) begin
							elem_d      = '0;
							col_d       = col_q + 1'b1;
							line_base_d = line_base_q + 32'(stride_q);
						end else begin
							elem_d = elem_q + 1'b1;
						end
						if (is_last) begin
							active_d = 1'b0;
							wp_we    = !cur_store_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cur_store_q <= 1'b0;
			cur_unit_q  <= '0;
			line_base_q <= '0;
			col_q       <= '0;
			elem_q      <= '0;
			bank_q      <= '0;
			row_q       <= '0;
			stride_q    <= '0;
			cols_q      <= '0;
			rows_q      <= '0;
			for (int i = 0; i < UNITS; i++) begin
				wp_q[i] <= '0;
			end
		end else begin
			active_q    <= active_d;
			cur_store_q <= cur_store_d;
			cur_unit_q  <= cur_unit_d;
			line_base_q <= line_base_d;
			col_q       <= col_d;
			elem_q      <= elem_d;
			bank_q      <= bank_d;
			row_q       <= row_d;
			stride_q    <= stride_d;
			cols_q      <= cols_d;
			rows_q      <= rows_d;
			if (wp_we) begin
				wp_q[UW'(cur_unit_q)] <= wp_wdata;
			end
		end
	end

	// The final tick of a tile must leave the unit idle.
	`TDBI_ASSERT_NEXT(a_last_ends_tile, clk, arst_n,
		go && (job.op == tdbi_pkg::OP_TICK) && active_q && is_last,
		!active_q, "tile still active after its final transfer")

	// A submit answered busy must not disturb the tile in progress.
	`TDBI_ASSERT_NEXT(a_busy_no_effect, clk, arst_n,
		go && (job.op == tdbi_pkg::OP_SUBMIT) && active_q,
		active_q && $stable(line_base_q) && $stable(cur_unit_q),
		"busy submit changed the active tile")

	// An accepted load starts one row above the unit's write pointer.
	`TDBI_ASSERT_NEXT(a_load_start_row, clk, arst_n,
		go && (job.op == tdbi_pkg::OP_SUBMIT) && !active_q && !job.is_store,
		active_q && (row_q == RW'($past(wp_rd) + 1'b1)),
		"load tile started at the wrong row")

	// The line counter never runs past the last line while a tile is active.
	`TDBI_ASSERT_NOW(a_col_in_range, clk, arst_n,
		active_q, col_q <= cols_q, "line counter beyond tile")

endmodule

### rtl/tile_dma_bank_interleave.sv
// ----------------------------------------------------------------------------
// Tile DMA bank interleave
// Address generator for a tile mover between DRAM and a banked slice buffer.
//
//   Channel   Handshake          Beat
//   item      push / full        submit or tick request (item_t)
//   result    pop / empty        submit status or transfer descriptor (result_t)
//   config    cfg_we             bank count, 5 bits, no read-back
//
// One item is taken per cycle while the job queue has room; its job is held in
// the job queue, then its result in the result queue, before the result shows;
// ticks give one transfer a cycle while a tile runs and the result queue has room.
// The back-end walk update sets that rate: one item per cycle while results have room.
// Reset clears the walk state, queue pointers and every unit's write pointer at once.
// full rises while the two-entry job queue is held up by a stalled result side.
// ----------------------------------------------------------------------------
module tile_dma_bank_interleave #(
	parameter int UNITS = tdbi_pkg::UNITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  tdbi_pkg::item_t                 item,
	output logic                            full,
	input  logic                            pop,
	output tdbi_pkg::result_t               result,
	output logic                            empty,
	input  logic                            cfg_we,
	input  logic [tdbi_pkg::BANK_CNT_W-1:0] cfg_data
);

	logic [tdbi_pkg::BANK_CNT_W-1:0] bank_count_q;
	tdbi_pkg::job_t                  job_in;
	tdbi_pkg::job_t                  job_head;
	logic                            job_empty;
	logic                            job_pop;
	tdbi_pkg::result_t               res;
	logic                            res_push;
	logic                            res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_count_q <= tdbi_pkg::BANK_COUNT_RESET;
		end else if (cfg_we) begin
			bank_count_q <= cfg_data;
		end
	end

	tdbi_front #(.UNITS(UNITS)) u_front (
		.item (item),
		.job  (job_in)
	);

	tdbi_queue #(.T(tdbi_pkg::job_t)) u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.full   (full),
		.pop    (job_pop),
		.rdata  (job_head),
		.empty  (job_empty)
	);

	tdbi_back #(.UNITS(UNITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.bank_count (bank_count_q),
		.job        (job_head),
		.job_empty  (job_empty),
		.job_pop    (job_pop),
		.res        (res),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	tdbi_queue #(.T(tdbi_pkg::result_t)) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
